// ===== rtl/paged_buffer_slot_allocator_core_defines.svh =====
// Assertion macros used by the checker of the slot allocator.
`ifndef PAGED_BUFFER_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define PAGED_BUFFER_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PBSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbsa same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PBSA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbsa next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define PBSA_ASSERT_RST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pbsa reset check failed");

`endif

// ===== rtl/pbsa_pkg.sv =====
package pbsa_pkg;

   localparam int NUM_PAGES      = 16;
   localparam int SLOTS_PER_PAGE = 8;

   localparam int PAGE_W   = $clog2(NUM_PAGES);
   localparam int SLOT_W   = $clog2(SLOTS_PER_PAGE);
   localparam int CNT_W    = $clog2(SLOTS_PER_PAGE + 1);
   localparam int TOTAL_W  = 8;
   localparam int DROP_W   = 16;
   localparam int STATUS_W = 3;

   localparam logic [CNT_W-1:0]   FULL_CNT   = CNT_W'(SLOTS_PER_PAGE);
   localparam logic [TOTAL_W-1:0] POOL_SIZE  = TOTAL_W'(NUM_PAGES * SLOTS_PER_PAGE);
   localparam logic [PAGE_W-1:0]  LAST_PAGE  = PAGE_W'(NUM_PAGES - 1);
   localparam logic [PAGE_W:0]    PAGE_LIMIT = (PAGE_W + 1)'(NUM_PAGES);
   localparam logic [SLOT_W:0]    SLOT_LIMIT = (SLOT_W + 1)'(SLOTS_PER_PAGE);

   localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DOUBLE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

   typedef struct packed {
      logic [SLOTS_PER_PAGE-1:0] map;
      logic [CNT_W-1:0]          cnt;
      logic [SLOT_W-1:0]         hint;
      logic [PAGE_W-1:0]         next;
      logic [PAGE_W-1:0]         prev;
   } page_rec_type;

   typedef struct packed {
      logic               en;
      logic [PAGE_W-1:0]  addr;
      page_rec_type       data;
   } mem_wr_type;

   typedef struct packed {
      logic              mode;
      logic [PAGE_W-1:0] page;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   page;
      logic [SLOT_W-1:0]   slot;
      logic [TOTAL_W-1:0]  buffers_free;
      logic [DROP_W-1:0]   drops;
   } result_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } scan_type;

   function automatic page_rec_type reset_rec(input logic [PAGE_W-1:0] p);
      page_rec_type r;
      r.map  = '1;
      r.cnt  = FULL_CNT;
      r.hint = '0;
      r.next = (p == LAST_PAGE) ? '0 : p + PAGE_W'(1);
      r.prev = (p == '0) ? LAST_PAGE : p - PAGE_W'(1);
      return r;
   endfunction

   // First free slot after the given one, scanning forward and wrapping.
   function automatic scan_type scan_next(input logic [SLOTS_PER_PAGE-1:0] map,
                                          input logic [SLOT_W-1:0] from);
      scan_type        r;
      logic [SLOT_W:0] s;
      r = '0;
      for (int k = SLOTS_PER_PAGE - 1; k >= 1; k--) begin
         s = {1'b0, from} + (SLOT_W + 1)'(k);
         if (s >= SLOT_LIMIT) begin
            s = s - SLOT_LIMIT;
         end
         if (map[s[SLOT_W-1:0]]) begin
            r.found = 1'b1;
            r.slot  = s[SLOT_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/pbsa_page_mem.sv =====
module pbsa_page_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pbsa_pkg::PAGE_W-1:0]   rd_addr,
   output pbsa_pkg::page_rec_type        rd_data,
   input  pbsa_pkg::mem_wr_type          wr
);
   import pbsa_pkg::*;

   page_rec_type       mem_ff [NUM_PAGES];
   logic [NUM_PAGES-1:0] valid_ff;
   logic               rd_valid_ff;
   logic [PAGE_W-1:0]  rd_addr_ff;
   page_rec_type       rd_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_q_ff    <= mem_ff[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // A page never written since reset reads as its reset record.
   assign rd_data = rd_valid_ff ? rd_q_ff : reset_rec(rd_addr_ff);

endmodule

// ===== rtl/pbsa_seq.sv =====
module pbsa_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  pbsa_pkg::req_type             req,
   output logic                          idle,
   input  logic                          rsp_free,
   output logic                          done,
   output pbsa_pkg::result_type          result,
   output logic [pbsa_pkg::PAGE_W-1:0]   rd_addr,
   input  pbsa_pkg::page_rec_type        rd_data,
   output pbsa_pkg::mem_wr_type          wr
);
   import pbsa_pkg::*;

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE = 4'd0;
   localparam logic [STATE_W-1:0] S_HEAD = 4'd1;
   localparam logic [STATE_W-1:0] S_WALK = 4'd2;
   localparam logic [STATE_W-1:0] S_FPV  = 4'd3;
   localparam logic [STATE_W-1:0] S_FNX  = 4'd4;
   localparam logic [STATE_W-1:0] S_A2R  = 4'd5;
   localparam logic [STATE_W-1:0] S_A2W  = 4'd6;
   localparam logic [STATE_W-1:0] S_A3R  = 4'd7;
   localparam logic [STATE_W-1:0] S_A3W  = 4'd8;
   localparam logic [STATE_W-1:0] S_A4   = 4'd9;
   localparam logic [STATE_W-1:0] S_A5W  = 4'd10;
   localparam logic [STATE_W-1:0] S_DONE = 4'd11;

   logic [STATE_W-1:0]  state_ff, state_in;
   logic [PAGE_W-1:0]   top_ff, top_in;
   logic [TOTAL_W-1:0]  free_ff, free_in;
   logic [DROP_W-1:0]   drop_ff, drop_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PAGE_W-1:0]   gpage_ff, gpage_in;
   logic [SLOT_W-1:0]   gslot_ff, gslot_in;
   logic                mode_ff, mode_in;
   logic [PAGE_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   page_rec_type        rec_ff, rec_in;
   page_rec_type        pvrec_ff, pvrec_in;
   logic [PAGE_W-1:0]   q_ff, q_in;
   logic [PAGE_W-1:0]   walk_ff, walk_in;
   logic [PAGE_W-1:0]   pv_ff, pv_in;
   logic [PAGE_W-1:0]   nx_ff, nx_in;
   logic [PAGE_W-1:0]   after_ff, after_in;
   page_rec_type        upd_rec;
   scan_type            scan_res;

   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      free_in   = free_ff;
      drop_in   = drop_ff;
      status_in = status_ff;
      gpage_in  = gpage_ff;
      gslot_in  = gslot_ff;
      mode_in   = mode_ff;
      cur_in    = cur_ff;
      slot_in   = slot_ff;
      rec_in    = rec_ff;
      pvrec_in  = pvrec_ff;
      q_in      = q_ff;
      walk_in   = walk_ff;
      pv_in     = pv_ff;
      nx_in     = nx_ff;
      after_in  = after_ff;
      upd_rec   = rd_data;
      scan_res  = '0;
      rd_addr   = top_ff;
      wr        = '0;
      done      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req.mode;
               gpage_in = '0;
               gslot_in = '0;
               if (!req.mode) begin
                  if (free_ff <= TOTAL_W'(1)) begin
                     drop_in   = drop_ff + DROP_W'(1);
                     status_in = ST_REFUSED;
                     state_in  = S_DONE;
                  end else begin
                     rd_addr  = top_ff;
                     cur_in   = top_ff;
                     state_in = S_HEAD;
                  end
               end else if ({1'b0, req.page} >= PAGE_LIMIT ||
                            {1'b0, req.slot} >= SLOT_LIMIT) begin
                  status_in = ST_BAD;
                  state_in  = S_DONE;
               end else begin
                  rd_addr  = req.page;
                  cur_in   = req.page;
                  slot_in  = req.slot;
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            if (!mode_ff) begin
               if (rd_data.cnt == '0 || !rd_data.map[rd_data.hint]) begin
                  status_in = ST_BAD;
                  state_in  = S_DONE;
               end else begin
                  upd_rec.map[rd_data.hint] = 1'b0;
                  upd_rec.cnt = rd_data.cnt - CNT_W'(1);
                  slot_in     = rd_data.hint;
                  if (upd_rec.cnt != '0) begin
                     scan_res = scan_next(upd_rec.map, rd_data.hint);
                     if (scan_res.found) begin
                        upd_rec.hint = scan_res.slot;
                        wr           = '{en: 1'b1, addr: cur_ff, data: upd_rec};
                        free_in      = free_ff - TOTAL_W'(1);
                        status_in    = ST_ALLOC;
                        gpage_in     = cur_ff;
                        gslot_in     = rd_data.hint;
                     end else begin
                        status_in = ST_BAD;
                     end
                     state_in = S_DONE;
                  end else if (rd_data.next == top_ff) begin
                     status_in = ST_BAD;
                     state_in  = S_DONE;
                  end else begin
                     rec_in   = upd_rec;
                     rd_addr  = rd_data.next;
                     q_in     = rd_data.next;
                     walk_in  = '0;
                     state_in = S_WALK;
                  end
               end
            end else begin
               if (rd_data.map[slot_ff]) begin
                  status_in = ST_DOUBLE;
                  state_in  = S_DONE;
               end else if (rd_data.cnt >= FULL_CNT) begin
                  status_in = ST_BAD;
                  state_in  = S_DONE;
               end else begin
                  upd_rec.map[slot_ff] = 1'b1;
                  upd_rec.hint = slot_ff;
                  upd_rec.cnt  = rd_data.cnt + CNT_W'(1);
                  wr           = '{en: 1'b1, addr: cur_ff, data: upd_rec};
                  free_in      = free_ff + TOTAL_W'(1);
                  status_in    = ST_FREED;
                  if (upd_rec.cnt == FULL_CNT) begin
                     rec_in   = upd_rec;
                     rd_addr  = rd_data.prev;
                     pv_in    = rd_data.prev;
                     nx_in    = rd_data.next;
                     state_in = S_FPV;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_WALK: begin
            if (rd_data.cnt != '0) begin
               wr        = '{en: 1'b1, addr: cur_ff, data: rec_ff};
               top_in    = q_ff;
               free_in   = free_ff - TOTAL_W'(1);
               status_in = ST_ALLOC;
               gpage_in  = cur_ff;
               gslot_in  = slot_ff;
               state_in  = S_DONE;
            end else if (walk_ff == LAST_PAGE || rd_data.next == top_ff) begin
               status_in = ST_BAD;
               state_in  = S_DONE;
            end else begin
               rd_addr = rd_data.next;
               q_in    = rd_data.next;
               walk_in = walk_ff + PAGE_W'(1);
            end
         end
         S_FPV: begin
            pvrec_in = rd_data;
            rd_addr  = nx_ff;
            state_in = S_FNX;
         end
         S_FNX: begin
            if (cur_ff != top_ff && pvrec_ff.cnt != FULL_CNT && rd_data.cnt != FULL_CNT) begin
               upd_rec      = pvrec_ff;
               upd_rec.next = nx_ff;
               wr           = '{en: 1'b1, addr: pv_ff, data: upd_rec};
               state_in     = S_A2R;
            end else begin
               if (rd_data.cnt == FULL_CNT) begin
                  top_in = cur_ff;
               end
               state_in = S_DONE;
            end
         end
         S_A2R: begin
            rd_addr  = nx_ff;
            state_in = S_A2W;
         end
         S_A2W: begin
            upd_rec.prev = pv_ff;
            wr           = '{en: 1'b1, addr: nx_ff, data: upd_rec};
            state_in     = S_A3R;
         end
         S_A3R: begin
            rd_addr  = top_ff;
            state_in = S_A3W;
         end
         S_A3W: begin
            after_in     = rd_data.next;
            upd_rec.next = cur_ff;
            wr           = '{en: 1'b1, addr: top_ff, data: upd_rec};
            state_in     = S_A4;
         end
         S_A4: begin
            upd_rec      = rec_ff;
            upd_rec.prev = top_ff;
            upd_rec.next = after_ff;
            wr           = '{en: 1'b1, addr: cur_ff, data: upd_rec};
            rd_addr      = after_ff;
            state_in     = S_A5W;
         end
         S_A5W: begin
            upd_rec.prev = cur_ff;
            wr           = '{en: 1'b1, addr: after_ff, data: upd_rec};
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         top_ff   <= '0;
         free_ff  <= POOL_SIZE;
         drop_ff  <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         free_ff  <= free_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      gpage_ff  <= gpage_in;
      gslot_ff  <= gslot_in;
      mode_ff   <= mode_in;
      cur_ff    <= cur_in;
      slot_ff   <= slot_in;
      rec_ff    <= rec_in;
      pvrec_ff  <= pvrec_in;
      q_ff      <= q_in;
      walk_ff   <= walk_in;
      pv_ff     <= pv_in;
      nx_ff     <= nx_in;
      after_ff  <= after_in;
   end

   assign idle   = (state_ff == S_IDLE);
   assign result = '{status: status_ff, page: gpage_ff, slot: gslot_ff,
                     buffers_free: free_ff, drops: drop_ff};

endmodule

// ===== rtl/paged_buffer_slot_allocator_core.sv =====
// Paged buffer slot allocator: a pool of pages, each split into buffer slots.
// Request channel (req_*): req_mode 0 allocates a buffer, 1 frees the buffer
// named by req_page_index and req_slot_index. Each request gives exactly one
// transfer on the result channel (rsp_*) with a status, the granted buffer on
// a successful allocate, the free buffer count and the running drop count.
// Requests are handled one at a time, with one page record memory read per
// step: a refused allocate goes straight to its result; an allocate reads the
// top page and, when that page runs out of free slots, walks the page list
// until it finds a page with a free slot; a free reads the named page, and
// when that leaves the page wholly free it reads the neighbouring pages and
// may relink the page after the top page. A new request is taken once the
// previous one has been written to the result register, in the cycle after.
// Reset is synchronous and takes effect at once: per-page valid bits make
// every page record read as its initial value, with no clearing pass.
// When the receiver stalls, the result holds in the output register; the next
// request is still taken and worked on, and waits at its end for the register.
module paged_buffer_slot_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [pbsa_pkg::PAGE_W-1:0]     req_page_index,
   input  logic [pbsa_pkg::SLOT_W-1:0]     req_slot_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pbsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pbsa_pkg::PAGE_W-1:0]     rsp_granted_page,
   output logic [pbsa_pkg::SLOT_W-1:0]     rsp_granted_slot,
   output logic [pbsa_pkg::TOTAL_W-1:0]    rsp_buffers_free,
   output logic [pbsa_pkg::DROP_W-1:0]     rsp_drops
);
   import pbsa_pkg::*;

   logic               seq_idle;
   logic               seq_done;
   logic               rsp_free;
   result_type         seq_result;
   req_type            req;
   logic [PAGE_W-1:0]  rd_addr;
   page_rec_type       rd_data;
   mem_wr_type         wr;
   logic               rsp_valid_ff;
   result_type         rsp_data_ff;

   assign req       = '{mode: req_mode, page: req_page_index, slot: req_slot_index};
   assign req_ready = seq_idle;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   pbsa_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && req_ready),
      .req      (req),
      .idle     (seq_idle),
      .rsp_free (rsp_free),
      .done     (seq_done),
      .result   (seq_result),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr       (wr)
   );

   pbsa_page_mem u_page_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_data_ff <= seq_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_granted_page = rsp_data_ff.page;
   assign rsp_granted_slot = rsp_data_ff.slot;
   assign rsp_buffers_free = rsp_data_ff.buffers_free;
   assign rsp_drops        = rsp_data_ff.drops;

endmodule

// ===== rtl/pbsa_checker.sv =====
`include "paged_buffer_slot_allocator_core_defines.svh"

module pbsa_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_mode,
   input  logic [pbsa_pkg::PAGE_W-1:0]     req_page_index,
   input  logic [pbsa_pkg::SLOT_W-1:0]     req_slot_index,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [pbsa_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [pbsa_pkg::PAGE_W-1:0]     rsp_granted_page,
   input  logic [pbsa_pkg::SLOT_W-1:0]     rsp_granted_slot,
   input  logic [pbsa_pkg::TOTAL_W-1:0]    rsp_buffers_free,
   input  logic [pbsa_pkg::DROP_W-1:0]     rsp_drops
);
   import pbsa_pkg::*;

   `PBSA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_buffers_free) && $stable(rsp_drops))
   `PBSA_ASSERT_IMP(a_grant_zero, clock, reset, rsp_valid && rsp_status != ST_ALLOC, rsp_granted_page == '0 && rsp_granted_slot == '0)
   `PBSA_ASSERT_IMP(a_refuse_low, clock, reset, rsp_valid && rsp_status == ST_REFUSED, rsp_buffers_free <= TOTAL_W'(1))
   `PBSA_ASSERT_IMP(a_free_bound, clock, reset, rsp_valid, rsp_buffers_free <= POOL_SIZE)
   `PBSA_ASSERT_RST(a_reset_clear, clock, reset, !rsp_valid)

endmodule

bind paged_buffer_slot_allocator_core pbsa_checker u_pbsa_checker (.*);
